// ===== rtl/assert_macros.svh =====
// assertion helpers, included by the top-level evaluator unit
// define NO_ASSERTIONS to compile every check away
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== rtl/csp_pkg.sv =====
// csp_pkg: widths, word types, basis coefficient table and divide-by-3 step
// for the cubic spline point evaluator; no dependencies
package csp_pkg;

	localparam int COORD_WIDTH = 32;
	localparam int T_FRAC_BITS = 16;
	localparam int OUT_W = 40;
	localparam int T_W = T_FRAC_BITS + 1;
	localparam int NPT = 5;
	localparam int TENS_W = 16;
	localparam int S_W = TENS_W + 1;
	localparam int COEF_W = 5;
	localparam int NPOW = 4;
	// base weights stay below 32 * 2^F in magnitude
	localparam int BW = T_FRAC_BITS + 6;
	localparam int WGT_W = BW + S_W + 1;
	localparam int ACC_W = WGT_W + COORD_WIDTH + 3;
	localparam int CARD_SHIFT = 15;
	localparam int YW = ACC_W + 1 - T_FRAC_BITS;
	localparam int QW = OUT_W + 1;
	localparam int DIG_W = 8;
	localparam int NDIG = (QW + DIG_W - 1) / DIG_W;
	localparam int DIV_W = NDIG * DIG_W;
	localparam int NDIG_HI = NDIG / 2;
	localparam int SH_W = $clog2(T_FRAC_BITS + CARD_SHIFT + 1);
	localparam int RECIP3 = 683;
	localparam int RECIP3_SHIFT = 11;
	localparam int STEP_W = DIG_W + 2 + RECIP3_SHIFT;

	localparam logic [T_W-1:0] T_ONE = {1'b1, {T_FRAC_BITS{1'b0}}};
	localparam logic [T_W-1:0] T_HALF = {2'b01, {(T_FRAC_BITS - 1){1'b0}}};
	localparam logic signed [S_W-1:0] S_BIAS = {3'b001, {(TENS_W - 2){1'b0}}};
	localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W - 1){1'b1}}};
	localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W - 1){1'b0}}};
	localparam logic [QW-1:0] LIM_POS = {{(QW - OUT_W + 1){1'b0}}, {(OUT_W - 1){1'b1}}};
	localparam logic [QW-1:0] LIM_NEG = {{(QW - OUT_W){1'b0}}, 1'b1, {(OUT_W - 1){1'b0}}};

	typedef enum logic [1:0] {
		FUNC_LINEAR   = 2'd0,
		FUNC_CARDINAL = 2'd1,
		FUNC_CATMULL  = 2'd2,
		FUNC_BSPLINE  = 2'd3
	} func_t;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;
	typedef logic signed [WGT_W-1:0] wgt_t;

	typedef struct packed {
		func_t func;
		logic want_derivative;
		logic [T_W-1:0] param_t;
		coord_t pt_start;
		coord_t pt_end;
		coord_t pt_ctrl1;
		coord_t pt_ctrl2;
		coord_t pt_ctrl3;
	} item_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] curve_value;
		logic saturated;
	} result_t;

	typedef struct packed {
		func_t func;
		wgt_t [NPT-1:0] w;
		coord_t [NPT-1:0] pts;
	} wgt_data_t;

	typedef struct packed {
		func_t func;
		logic signed [ACC_W-1:0] acc;
	} acc_data_t;

	// [basis][derivative][slot][t^3, t^2, t, 1]
	// slots: start, end, ctrl1, ctrl2, ctrl3
	localparam logic signed [COEF_W-1:0] BASIS_TAB [4][2][NPT][NPOW] = '{
		'{
			'{'{5'sd0, 5'sd0, -5'sd1, 5'sd1}, '{5'sd0, 5'sd0, 5'sd1, 5'sd0},
			  '{5'sd0, 5'sd0, 5'sd0, 5'sd0}, '{5'sd0, 5'sd0, 5'sd0, 5'sd0},
			  '{5'sd0, 5'sd0, 5'sd0, 5'sd0}},
			'{'{5'sd0, 5'sd0, 5'sd0, -5'sd1}, '{5'sd0, 5'sd0, 5'sd0, 5'sd1},
			  '{5'sd0, 5'sd0, 5'sd0, 5'sd0}, '{5'sd0, 5'sd0, 5'sd0, 5'sd0},
			  '{5'sd0, 5'sd0, 5'sd0, 5'sd0}}
		},
		'{
			'{'{5'sd2, -5'sd3, 5'sd0, 5'sd1}, '{-5'sd2, 5'sd3, 5'sd0, 5'sd0},
			  '{5'sd1, -5'sd2, 5'sd1, 5'sd0}, '{5'sd1, -5'sd1, 5'sd0, 5'sd0},
			  '{5'sd0, 5'sd0, 5'sd0, 5'sd0}},
			'{'{5'sd0, 5'sd6, -5'sd6, 5'sd0}, '{5'sd0, -5'sd6, 5'sd6, 5'sd0},
			  '{5'sd0, 5'sd3, -5'sd4, 5'sd1}, '{5'sd0, 5'sd3, -5'sd2, 5'sd0},
			  '{5'sd0, 5'sd0, 5'sd0, 5'sd0}}
		},
		'{
			'{'{5'sd3, -5'sd5, 5'sd0, 5'sd2}, '{-5'sd3, 5'sd4, 5'sd1, 5'sd0},
			  '{-5'sd1, 5'sd2, -5'sd1, 5'sd0}, '{5'sd1, -5'sd1, 5'sd0, 5'sd0},
			  '{5'sd0, 5'sd0, 5'sd0, 5'sd0}},
			'{'{5'sd0, 5'sd9, -5'sd10, 5'sd0}, '{5'sd0, -5'sd9, 5'sd8, 5'sd1},
			  '{5'sd0, -5'sd3, 5'sd4, -5'sd1}, '{5'sd0, 5'sd3, -5'sd2, 5'sd0},
			  '{5'sd0, 5'sd0, 5'sd0, 5'sd0}}
		},
		'{
			'{'{5'sd1, 5'sd0, 5'sd0, 5'sd0}, '{5'sd0, 5'sd0, 5'sd0, 5'sd0},
			  '{-5'sd1, 5'sd3, -5'sd3, 5'sd1}, '{5'sd3, -5'sd6, 5'sd0, 5'sd4},
			  '{-5'sd3, 5'sd3, 5'sd3, 5'sd1}},
			'{'{5'sd0, 5'sd3, 5'sd0, 5'sd0}, '{5'sd0, 5'sd0, 5'sd0, 5'sd0},
			  '{5'sd0, -5'sd3, 5'sd6, -5'sd3}, '{5'sd0, 5'sd9, -5'sd12, 5'sd0},
			  '{5'sd0, -5'sd9, 5'sd6, 5'sd3}}
		}
	};

	// one long-division digit by 3: returns {quotient digit, remainder}
	function automatic logic [DIG_W+1:0] div3_step(input logic [1:0] rem,
		input logic [DIG_W-1:0] dig);
		logic [DIG_W+1:0] cur;
		logic [STEP_W-1:0] prod;
		logic [DIG_W-1:0] q;
		logic [DIG_W+1:0] r;
		cur = {rem, dig};
		// reciprocal multiply is exact while cur stays below 3 * 2^DIG_W
		prod = STEP_W'(cur) * STEP_W'(RECIP3);
		q = prod[RECIP3_SHIFT +: DIG_W];
		r = cur - ((DIG_W + 2)'(q) << 1) - (DIG_W + 2)'(q);
		return {q, r[1:0]};
	endfunction

endpackage

// ===== rtl/csp_weights.sv =====
// csp_weights: t^2 and t^3, basis weights and cardinal tension mixing (s2..s5)
// depends on csp_pkg
module csp_weights import csp_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  item_t                   in_item,
	input  logic signed [S_W-1:0]   in_s,
	output logic                    out_valid,
	output wgt_data_t               out_data
);

	logic valid_s2, valid_s3, valid_s4, valid_s5;
	item_t item_s2, item_s3, item_s4;
	logic signed [S_W-1:0] s_s2, s_s3, s_s4;
	logic [T_W-1:0] t2_s2, t2_s3;
	logic [T_W-1:0] t3_s3;
	logic signed [BW-1:0] base_s4 [NPT];
	wgt_data_t data_s5;

	logic [2*T_W-1:0] sq;
	logic [2*T_W-1:0] cube;
	logic signed [BW-1:0] pw [NPOW];
	logic signed [BW-1:0] base_next [NPT];
	logic signed [WGT_W-1:0] m0, m1;
	wgt_t [NPT-1:0] w_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s2 <= in_valid;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	// t^2 and t^3 with round half up
	always_comb begin
		sq = (2*T_W)'(in_item.param_t) * (2*T_W)'(in_item.param_t) + (2*T_W)'(T_HALF);
		cube = (2*T_W)'(t2_s2) * (2*T_W)'(item_s2.param_t) + (2*T_W)'(T_HALF);
	end

	always_comb begin
		pw[0] = $signed(BW'(t3_s3));
		pw[1] = $signed(BW'(t2_s3));
		pw[2] = $signed(BW'(item_s3.param_t));
		pw[3] = $signed(BW'(T_ONE));
		for (int i = 0; i < NPT; i++) begin
			base_next[i] = '0;
			for (int j = 0; j < NPOW; j++) begin
				base_next[i] = base_next[i] +
					BW'(BASIS_TAB[item_s3.func][item_s3.want_derivative][i][j]) * pw[j];
			end
		end
	end

	// cardinal: tangent weights scaled by (16384 - tension), the rest by 32768
	always_comb begin
		m0 = WGT_W'(s_s4 * base_s4[2]);
		m1 = WGT_W'(s_s4 * base_s4[3]);
		if (item_s4.func == FUNC_CARDINAL) begin
			w_next[0] = (WGT_W'(base_s4[0]) <<< CARD_SHIFT) - m1;
			w_next[1] = (WGT_W'(base_s4[1]) <<< CARD_SHIFT) + m0;
			w_next[2] = -m0;
			w_next[3] = m1;
			w_next[4] = '0;
		end else begin
			for (int i = 0; i < NPT; i++) begin
				w_next[i] = WGT_W'(base_s4[i]);
			end
		end
	end

	always_ff @(posedge clk) begin
		item_s2 <= in_item;
		s_s2 <= in_s;
		t2_s2 <= sq[T_FRAC_BITS +: T_W];

		item_s3 <= item_s2;
		s_s3 <= s_s2;
		t2_s3 <= t2_s2;
		t3_s3 <= cube[T_FRAC_BITS +: T_W];

		item_s4 <= item_s3;
		s_s4 <= s_s3;
		for (int i = 0; i < NPT; i++) begin
			base_s4[i] <= base_next[i];
		end

		data_s5.func <= item_s4.func;
		data_s5.w <= w_next;
		data_s5.pts[0] <= item_s4.pt_start;
		data_s5.pts[1] <= item_s4.pt_end;
		data_s5.pts[2] <= item_s4.pt_ctrl1;
		data_s5.pts[3] <= item_s4.pt_ctrl2;
		data_s5.pts[4] <= item_s4.pt_ctrl3;
	end

	assign out_valid = valid_s5;
	assign out_data = data_s5;

endmodule

// ===== rtl/csp_mac.sv =====
// csp_mac: weight by coordinate products in split halves and the five-lane sum (s6..s9)
// depends on csp_pkg
module csp_mac import csp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  wgt_data_t in_data,
	output logic      out_valid,
	output acc_data_t out_data
);

	localparam int H = COORD_WIDTH / 2;
	localparam int PPL_W = WGT_W + H + 1;
	localparam int PPH_W = WGT_W + COORD_WIDTH - H;

	logic valid_s6, valid_s7, valid_s8, valid_s9;
	func_t func_s6, func_s7, func_s8;
	logic signed [PPL_W-1:0] pp_lo_s6 [NPT];
	logic signed [PPH_W-1:0] pp_hi_s6 [NPT];
	logic signed [ACC_W-1:0] prod_s7 [NPT];
	logic signed [ACC_W-1:0] sum01_s8, sum23_s8, last_s8;
	acc_data_t data_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
			valid_s8 <= 1'b0;
			valid_s9 <= 1'b0;
		end else begin
			valid_s6 <= in_valid;
			valid_s7 <= valid_s6;
			valid_s8 <= valid_s7;
			valid_s9 <= valid_s8;
		end
	end

	always_ff @(posedge clk) begin
		// low half taken unsigned, high half signed
		for (int i = 0; i < NPT; i++) begin
			pp_lo_s6[i] <= PPL_W'($signed(in_data.w[i]) *
				$signed({1'b0, in_data.pts[i][H-1:0]}));
			pp_hi_s6[i] <= PPH_W'($signed(in_data.w[i]) *
				$signed(in_data.pts[i][COORD_WIDTH-1:H]));
		end
		func_s6 <= in_data.func;

		for (int i = 0; i < NPT; i++) begin
			prod_s7[i] <= (ACC_W'(pp_hi_s6[i]) <<< H) + ACC_W'(pp_lo_s6[i]);
		end
		func_s7 <= func_s6;

		sum01_s8 <= prod_s7[0] + prod_s7[1];
		sum23_s8 <= prod_s7[2] + prod_s7[3];
		last_s8 <= prod_s7[4];
		func_s8 <= func_s7;

		data_s9.acc <= sum01_s8 + sum23_s8 + last_s8;
		data_s9.func <= func_s8;
	end

	assign out_valid = valid_s9;
	assign out_data = data_s9;

endmodule

// ===== rtl/csp_round.sv =====
// csp_round: magnitude, scale with round half away from zero, divide by 3 for
// b-spline, 40-bit saturation (s10..s14); depends on csp_pkg
module csp_round import csp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  acc_data_t in_data,
	output logic      out_valid,
	output result_t   out_result
);

	logic valid_s10, valid_s11, valid_s12, valid_s13, valid_s14;
	func_t func_s10, func_s11, func_s12;
	logic neg_s10, neg_s11, neg_s12, neg_s13;
	logic big_s11, big_s12, big_s13;
	logic [ACC_W-1:0] mag_s10;
	logic [QW-1:0] y_s11, y_s12;
	logic [DIV_W-1:0] q_s12;
	logic [1:0] rem_s12;
	logic [QW-1:0] quot_s13;
	result_t result_s14;

	logic [ACC_W:0] half;
	logic [SH_W-1:0] shamt;
	logic [ACC_W:0] rsum;
	logic [YW-1:0] y;
	logic [DIV_W-1:0] q12, q13;
	logic [1:0] rem12, rem13;
	logic [DIG_W+1:0] step12, step13;
	logic [QW-1:0] limit;
	logic sat;
	logic [QW-1:0] mag_q;
	logic [OUT_W-1:0] mag_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s10 <= 1'b0;
			valid_s11 <= 1'b0;
			valid_s12 <= 1'b0;
			valid_s13 <= 1'b0;
			valid_s14 <= 1'b0;
		end else begin
			valid_s10 <= in_valid;
			valid_s11 <= valid_s10;
			valid_s12 <= valid_s11;
			valid_s13 <= valid_s12;
			valid_s14 <= valid_s13;
		end
	end

	// b-spline divisor is 6 * 2^F: add half of it, shift by F+1, then divide by 3
	always_comb begin
		unique case (func_s10)
			FUNC_LINEAR: begin
				half = (ACC_W + 1)'(1) << (T_FRAC_BITS - 1);
				shamt = SH_W'(T_FRAC_BITS);
			end
			FUNC_CARDINAL: begin
				half = (ACC_W + 1)'(1) << (T_FRAC_BITS + CARD_SHIFT - 1);
				shamt = SH_W'(T_FRAC_BITS + CARD_SHIFT);
			end
			FUNC_CATMULL: begin
				half = (ACC_W + 1)'(1) << T_FRAC_BITS;
				shamt = SH_W'(T_FRAC_BITS + 1);
			end
			FUNC_BSPLINE: begin
				half = (ACC_W + 1)'(3) << T_FRAC_BITS;
				shamt = SH_W'(T_FRAC_BITS + 1);
			end
			default: begin
				half = '0;
				shamt = '0;
			end
		endcase
		rsum = {1'b0, mag_s10} + half;
		y = YW'(rsum >> shamt);
	end

	// long division by 3, upper digits
	always_comb begin
		q12 = {{(DIV_W - QW){1'b0}}, y_s11};
		rem12 = '0;
		step12 = '0;
		for (int d = NDIG - 1; d >= NDIG - NDIG_HI; d--) begin
			step12 = div3_step(rem12, q12[d*DIG_W +: DIG_W]);
			q12[d*DIG_W +: DIG_W] = step12[DIG_W+1:2];
			rem12 = step12[1:0];
		end
	end

	// lower digits
	always_comb begin
		q13 = q_s12;
		rem13 = rem_s12;
		step13 = '0;
		for (int d = NDIG - NDIG_HI - 1; d >= 0; d--) begin
			step13 = div3_step(rem13, q13[d*DIG_W +: DIG_W]);
			q13[d*DIG_W +: DIG_W] = step13[DIG_W+1:2];
			rem13 = step13[1:0];
		end
	end

	always_comb begin
		limit = neg_s13 ? LIM_NEG : LIM_POS;
		sat = big_s13 || (quot_s13 > limit);
		mag_q = sat ? limit : quot_s13;
		mag_out = mag_q[OUT_W-1:0];
	end

	always_ff @(posedge clk) begin
		neg_s10 <= in_data.acc[ACC_W-1];
		mag_s10 <= in_data.acc[ACC_W-1] ? $unsigned(-in_data.acc) : $unsigned(in_data.acc);
		func_s10 <= in_data.func;

		y_s11 <= y[QW-1:0];
		big_s11 <= |y[YW-1:QW];
		neg_s11 <= neg_s10;
		func_s11 <= func_s10;

		q_s12 <= q12;
		rem_s12 <= rem12;
		y_s12 <= y_s11;
		big_s12 <= big_s11;
		neg_s12 <= neg_s11;
		func_s12 <= func_s11;

		quot_s13 <= (func_s12 == FUNC_BSPLINE) ? q13[QW-1:0] : y_s12;
		big_s13 <= big_s12;
		neg_s13 <= neg_s12;

		result_s14.curve_value <= $signed(neg_s13 ? -mag_out : mag_out);
		result_s14.saturated <= sat;
	end

	assign out_valid = valid_s14;
	assign out_result = result_s14;

endmodule

// ===== rtl/cubic_spline_point_evaluator_unit.sv =====
// cubic spline point evaluator: one coordinate of a curve piece per word
// a word is taken when start is high and busy is low, one word per clock while busy stays low
// fourteen register stages: t powers, weights, split products, adder tree, rounding, divide by 3
// reset clears all valid bits and tension to 0; busy is high in reset and in the cycle after reset is released
// the result strobe lasts one cycle and cannot be held off; depends on csp_pkg
`include "assert_macros.svh"
module cubic_spline_point_evaluator_unit import csp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  item_t             item,
	output logic              result_valid,
	output result_t           result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [TENS_W-1:0] cfg_data
);

	logic signed [TENS_W-1:0] tension_q;
	logic busy_q;
	logic accept;
	item_t item_clamped;
	logic at_limit;

	logic valid_s1;
	item_t item_s1;
	logic signed [S_W-1:0] s_s1;

	logic wgt_valid;
	wgt_data_t wgt_data;
	logic acc_valid;
	acc_data_t acc_data;

	assign cfg_ready = 1'b1;
	assign busy = busy_q;
	assign accept = start && !busy_q;
	assign at_limit = (result.curve_value == OUT_MAX) || (result.curve_value == OUT_MIN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tension_q <= '0;
			busy_q <= 1'b1;
			valid_s1 <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				tension_q <= $signed(cfg_data);
			end
			busy_q <= 1'b0;
			valid_s1 <= accept;
		end
	end

	// t above one counts as one
	always_comb begin
		item_clamped = item;
		if (item.param_t > T_ONE) begin
			item_clamped.param_t = T_ONE;
		end
	end

	always_ff @(posedge clk) begin
		item_s1 <= item_clamped;
		s_s1 <= S_BIAS - S_W'(tension_q);
	end

	csp_weights u_weights (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_s1),
		.in_item  (item_s1),
		.in_s     (s_s1),
		.out_valid(wgt_valid),
		.out_data (wgt_data)
	);

	csp_mac u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (wgt_valid),
		.in_data  (wgt_data),
		.out_valid(acc_valid),
		.out_data (acc_data)
	);

	csp_round u_round (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (acc_valid),
		.in_data   (acc_data),
		.out_valid (result_valid),
		.out_result(result)
	);

	`ASSERT_IMPLIES(a_result_latency, clk, arst_n, accept, ##14 result_valid, "word lost")
	`ASSERT_IMPLIES(a_result_origin, clk, arst_n, result_valid, $past(accept, 14), "stray result")
	`ASSERT_IMPLIES(a_sat_clamped, clk, arst_n, result_valid && result.saturated, at_limit, "bad clamp")
	`ASSERT_IMPLIES(a_tension_hold, clk, arst_n, !cfg_valid, ##1 $stable(tension_q), "tension moved")

endmodule
